@@ rtl/stereo_gain_mixer_saturating_defines.svh @@
// Assertion macros for the stereo gain mixer.
// Depends on nothing; included by the top level only.
`ifndef STEREO_GAIN_MIXER_SATURATING_DEFINES_SVH
`define STEREO_GAIN_MIXER_SATURATING_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SGM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sgm_pkg.sv @@
// Package for the stereo gain mixer: widths, saturation bounds and the
// saturating accumulate function. Depends on nothing.
package sgm_pkg;

  localparam int GAIN_FRAC_BITS = 15;

  localparam int SMP_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int DIGIT_W     = 4;
  localparam int DIGITS      = GAIN_W / DIGIT_W;
  localparam int CNT_W       = $clog2(DIGITS);
  localparam int GG_W        = 2 * GAIN_W;
  localparam int PROD_W      = GG_W + SMP_W;
  localparam int SCALE_SHIFT = 2 * GAIN_FRAC_BITS;
  localparam int RES_W       = PROD_W - SCALE_SHIFT;
  localparam int WIDE_W      = RES_W + 2;

  localparam logic signed [SMP_W-1:0] SUM_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SUM_MIN = 16'sh8000;

  typedef logic signed [SMP_W-1:0] sample_t;

  // Add a sign-magnitude term to a sum and clamp to the sample range.
  function automatic sample_t sat_add(sample_t sum, logic neg, logic [RES_W-1:0] mag);
    logic signed [WIDE_W-1:0] acc;
    logic signed [WIDE_W-1:0] term;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    sample_t                  res;
    term = signed'({2'b00, mag});
    if (neg) begin
      term = -term;
    end
    acc = {{(WIDE_W-SMP_W){sum[SMP_W-1]}}, sum} + term;
    hi  = {{(WIDE_W-SMP_W){SUM_MAX[SMP_W-1]}}, SUM_MAX};
    lo  = {{(WIDE_W-SMP_W){SUM_MIN[SMP_W-1]}}, SUM_MIN};
    if (acc > hi) begin
      res = SUM_MAX;
    end else if (acc < lo) begin
      res = SUM_MIN;
    end else begin
      res = acc[SMP_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/stereo_gain_mixer_saturating.sv @@
// Stereo mixer: each transfer on the input channel adds one stream's left and
// right samples, scaled by the stream gain and the master gain (unsigned Q1.15,
// truncated toward zero), to saturating 16-bit running sums; a transfer with
// frame_end set emits the frame and clears the sums. An item with a sample
// goes through states that form the combined gain and then scale both
// samples, each in 4-bit digits through a shift-add multiplier, and then
// accumulate; an item without a sample goes straight to accumulate. A new
// item is taken only after the last is accumulated. The input is taken
// again while a finished frame still waits on the output register.
// Depends on sgm_pkg and stereo_gain_mixer_saturating_defines.svh.
`include "stereo_gain_mixer_saturating_defines.svh"

module stereo_gain_mixer_saturating (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sgm_pkg::GAIN_W-1:0]         cfg_master_gain_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [sgm_pkg::SMP_W-1:0]   left_in_i,
  input  logic signed [sgm_pkg::SMP_W-1:0]   right_in_i,
  input  logic [sgm_pkg::GAIN_W-1:0]         stream_gain_i,
  input  logic                               has_sample_i,
  input  logic                               frame_end_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sgm_pkg::SMP_W-1:0]   mixed_left_o,
  output logic signed [sgm_pkg::SMP_W-1:0]   mixed_right_o
);
  import sgm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_GAIN  = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_ACC   = 2'd3;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [GAIN_W-1:0] master_gain_q;
  logic              last_q;
  logic              neg_l_q, neg_r_q;
  logic [GG_W-1:0]   gp_q, gp_d;
  logic [PROD_W-1:0] pl_q, pl_d, pr_q, pr_d;
  sample_t           left_sum_q, left_sum_d, right_sum_q, right_sum_d;
  logic              out_valid_q, out_valid_d;
  sample_t           out_l_q, out_r_q;

  logic                        in_xfer;
  logic                        emit;
  logic                        acc_go;
  logic [GAIN_W+DIGIT_W-1:0]   gsum;
  logic [GG_W+DIGIT_W-1:0]     lsum, rsum;
  logic [SMP_W-1:0]            mag_l, mag_r;
  sample_t                     new_l, new_r;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_xfer      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign mixed_left_o  = out_l_q;
  assign mixed_right_o = out_r_q;

  assign mag_l = left_in_i[SMP_W-1]  ? (~left_in_i  + SMP_W'(1)) : left_in_i;
  assign mag_r = right_in_i[SMP_W-1] ? (~right_in_i + SMP_W'(1)) : right_in_i;

  // One digit step of each shift-add multiplier.
  assign gsum = {{DIGIT_W{1'b0}}, gp_q[GG_W-1:GAIN_W]}
              + (GAIN_W+DIGIT_W)'(master_gain_q * gp_q[DIGIT_W-1:0]);
  assign lsum = {{DIGIT_W{1'b0}}, pl_q[PROD_W-1:SMP_W]}
              + (GG_W+DIGIT_W)'(gp_q * pl_q[DIGIT_W-1:0]);
  assign rsum = {{DIGIT_W{1'b0}}, pr_q[PROD_W-1:SMP_W]}
              + (GG_W+DIGIT_W)'(gp_q * pr_q[DIGIT_W-1:0]);

  assign new_l = sat_add(left_sum_q,  neg_l_q, pl_q[PROD_W-1 -: RES_W]);
  assign new_r = sat_add(right_sum_q, neg_r_q, pr_q[PROD_W-1 -: RES_W]);

  assign acc_go = (state_q == ST_ACC) && !(last_q && out_valid_q && !out_ready_i);
  assign emit   = acc_go && last_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    gp_d        = gp_q;
    pl_d        = pl_q;
    pr_d        = pr_q;
    left_sum_d  = left_sum_q;
    right_sum_d = right_sum_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          gp_d    = {{GAIN_W{1'b0}}, stream_gain_i};
          pl_d    = {{GG_W{1'b0}}, mag_l};
          pr_d    = {{GG_W{1'b0}}, mag_r};
          cnt_d   = '0;
          state_d = has_sample_i ? ST_GAIN : ST_ACC;
        end
      end
      ST_GAIN: begin
        gp_d  = {gsum, gp_q[GAIN_W-1:DIGIT_W]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        pl_d  = {lsum, pl_q[SMP_W-1:DIGIT_W]};
        pr_d  = {rsum, pr_q[SMP_W-1:DIGIT_W]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (acc_go) begin
          state_d = ST_IDLE;
          if (last_q) begin
            left_sum_d  = '0;
            right_sum_d = '0;
          end else begin
            left_sum_d  = new_l;
            right_sum_d = new_r;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      master_gain_q <= GAIN_W'(32768);
      left_sum_q    <= '0;
      right_sum_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      left_sum_q  <= left_sum_d;
      right_sum_q <= right_sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        master_gain_q <= cfg_master_gain_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gp_q <= gp_d;
    pl_q <= pl_d;
    pr_q <= pr_d;
    if (in_xfer) begin
      last_q  <= frame_end_i;
      // Drop the sign of a sample that is not added.
      neg_l_q <= left_in_i[SMP_W-1]  && has_sample_i;
      neg_r_q <= right_in_i[SMP_W-1] && has_sample_i;
    end
    if (emit) begin
      out_l_q <= new_l;
      out_r_q <= new_r;
    end
  end

  `SGM_ASSERT_NEXT(a_xfer_leaves_idle, clk_i, rst_ni, in_xfer, state_q != ST_IDLE, "transfer taken but block stayed idle")
  `SGM_ASSERT_NEXT(a_emit_clears_sums, clk_i, rst_ni, emit, (left_sum_q == '0) && (right_sum_q == '0) && out_valid_q, "frame emitted without clearing sums")
  `SGM_ASSERT_SAME(a_cnt_idle_zero, clk_i, rst_ni, (state_q == ST_IDLE) || (state_q == ST_ACC), cnt_q == '0, "digit counter not at rest")

endmodule

@@ tb/tb_stereo_gain_mixer_saturating.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stereo_gain_mixer_saturating: directed and random frames,
// checked against a frame predictor in this file. Depends on sgm_pkg and the mixer RTL.
module tb_stereo_gain_mixer_saturating;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned RANDOM_ITEMS   = 380;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam logic [15:0] GAIN_UNITY     = 16'd32768;
  localparam logic [15:0] GAIN_MAX       = 16'hFFFF;

  typedef logic [sgm_pkg::GAIN_W-1:0] gain_t;
  typedef struct packed {
    sgm_pkg::sample_t left;
    sgm_pkg::sample_t right;
  } frame_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  gain_t            cfg_master_gain_i;
  logic             in_valid_i;
  logic             in_ready_o;
  sgm_pkg::sample_t left_in_i;
  sgm_pkg::sample_t right_in_i;
  gain_t            stream_gain_i;
  logic             has_sample_i;
  logic             frame_end_i;
  logic             out_valid_o;
  logic             out_ready_i;
  sgm_pkg::sample_t mixed_left_o;
  sgm_pkg::sample_t mixed_right_o;

  frame_t           frame_q[$];
  sgm_pkg::sample_t pred_left;
  sgm_pkg::sample_t pred_right;
  gain_t            master_gain;
  int unsigned      mismatches;
  int unsigned      hold_request;

  stereo_gain_mixer_saturating u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_master_gain_i (cfg_master_gain_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .left_in_i         (left_in_i),
    .right_in_i        (right_in_i),
    .stream_gain_i     (stream_gain_i),
    .has_sample_i      (has_sample_i),
    .frame_end_i       (frame_end_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .mixed_left_o      (mixed_left_o),
    .mixed_right_o     (mixed_right_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic sgm_pkg::sample_t scaled_sum(sgm_pkg::sample_t acc, sgm_pkg::sample_t smp,
                                                  gain_t g, gain_t mg);
    longint mag;
    longint total;
    mag = (smp < 0) ? -longint'(smp) : longint'(smp);
    mag = (mag * longint'(g) * longint'(mg)) >> (2 * sgm_pkg::GAIN_FRAC_BITS);
    total = longint'(acc) + ((smp < 0) ? -mag : mag);
    if (total > longint'(sgm_pkg::SUM_MAX)) begin
      return sgm_pkg::SUM_MAX;
    end else if (total < longint'(sgm_pkg::SUM_MIN)) begin
      return sgm_pkg::SUM_MIN;
    end
    return total[15:0];
  endfunction

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned next_gap(bit burst);
    if (burst || $urandom_range(0, 2) != 0) begin
      return 0;
    end
    return pick_gap();
  endfunction

  function automatic sgm_pkg::sample_t random_sample();
    case ($urandom_range(0, 7))
      0: return sgm_pkg::SUM_MAX;
      1: return sgm_pkg::SUM_MIN;
      2: return sgm_pkg::sample_t'($urandom_range(0, 2)) - 16'sd1;
      default: return sgm_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic gain_t random_gain();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return GAIN_UNITY;
      3: return gain_t'($urandom_range(32769, 65535));
      default: return gain_t'($urandom_range(0, 32768));
    endcase
  endfunction

  // Frame checker: compare each output transfer with the oldest predicted frame.
  always @(posedge clk_i) begin : check_frames
    frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_q.size() == 0) begin
        note_error($sformatf("unexpected frame left=%0d right=%0d",
                             mixed_left_o, mixed_right_o));
      end else begin
        want = frame_q.pop_front();
        if (mixed_left_o !== want.left || mixed_right_o !== want.right) begin
          note_error($sformatf("frame mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
                               want.left, want.right, mixed_left_o, mixed_right_o));
        end
      end
    end
  end

  initial begin : out_ready_driver
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned run_left;
    stall_left = 0;
    hold_left  = 0;
    run_left   = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (run_left != 0) begin
          run_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          run_left = $urandom_range(40, 120);
        end else if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_stereo_gain_mixer_saturating: errors");
    $finish;
  end

  task automatic send_contribution(input sgm_pkg::sample_t l, input sgm_pkg::sample_t r,
                                   input gain_t g, input bit has, input bit last,
                                   input int unsigned gap);
    frame_t done_frame;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    left_in_i     <= l;
    right_in_i    <= r;
    stream_gain_i <= g;
    has_sample_i  <= has;
    frame_end_i   <= last;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (has) begin
      pred_left  = scaled_sum(pred_left, l, g, master_gain);
      pred_right = scaled_sum(pred_right, r, g, master_gain);
    end
    if (last) begin
      done_frame.left  = pred_left;
      done_frame.right = pred_right;
      frame_q.insert(frame_q.size(), done_frame);
      pred_left  = '0;
      pred_right = '0;
    end
  endtask

  task automatic drain_frames();
    in_valid_i <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_master_gain(input gain_t value);
    drain_frames();
    cfg_master_gain_i <= value;
    cfg_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    master_gain = value;
  endtask

  task automatic test_unity_extremes();
    send_contribution(sgm_pkg::SUM_MAX, sgm_pkg::SUM_MIN, GAIN_UNITY, 1'b1, 1'b1, next_gap(0));
    send_contribution(-16'sd1, 16'sd1, GAIN_UNITY, 1'b1, 1'b1, next_gap(0));
    send_contribution(sgm_pkg::SUM_MIN, sgm_pkg::SUM_MAX, '0, 1'b1, 1'b1, next_gap(0));
    send_contribution(16'sd12345, -16'sd12345, 16'd16384, 1'b1, 1'b0, next_gap(0));
    send_contribution(16'sd1, -16'sd1, 16'd1, 1'b1, 1'b1, next_gap(0));
  endtask

  task automatic test_empty_contributions();
    send_contribution(16'sd777, -16'sd777, GAIN_UNITY, 1'b0, 1'b1, next_gap(0));
    send_contribution(16'sd1000, 16'sd2000, GAIN_UNITY, 1'b1, 1'b0, next_gap(0));
    send_contribution(random_sample(), random_sample(), GAIN_UNITY, 1'b0, 1'b0, next_gap(0));
    send_contribution(-16'sd500, 16'sd0, GAIN_UNITY, 1'b0, 1'b1, next_gap(0));
  endtask

  task automatic test_saturation();
    repeat (3) begin
      send_contribution(sgm_pkg::SUM_MAX, sgm_pkg::SUM_MIN, GAIN_UNITY, 1'b1, 1'b0, next_gap(0));
    end
    send_contribution(sgm_pkg::SUM_MIN, sgm_pkg::SUM_MAX, GAIN_UNITY, 1'b1, 1'b1, next_gap(0));
    send_contribution(16'sd20000, -16'sd20000, GAIN_MAX, 1'b1, 1'b1, next_gap(0));
  endtask

  task automatic test_master_gain_sweep();
    write_master_gain('0);
    send_contribution(sgm_pkg::SUM_MAX, sgm_pkg::SUM_MIN, GAIN_UNITY, 1'b1, 1'b1, next_gap(0));
    write_master_gain(16'd1);
    send_contribution(sgm_pkg::SUM_MAX, sgm_pkg::SUM_MIN, GAIN_MAX, 1'b1, 1'b1, next_gap(0));
    write_master_gain(GAIN_MAX);
    send_contribution(16'sd16384, -16'sd16384, GAIN_MAX, 1'b1, 1'b1, next_gap(0));
    write_master_gain(GAIN_UNITY);
    send_contribution(16'sd100, -16'sd100, GAIN_UNITY, 1'b1, 1'b1, next_gap(0));
  endtask

  task automatic test_output_backpressure();
    drain_frames();
    @(negedge clk_i);
    hold_request = 300;
    @(posedge clk_i);
    repeat (40) begin
      send_contribution(random_sample(), random_sample(), random_gain(), 1'b1, 1'b1, 0);
    end
    drain_frames();
  endtask

  task automatic test_random_mix();
    int unsigned sent;
    int unsigned frame_len;
    bit          burst;
    bit          has;
    bit          last;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        write_master_gain(random_gain());
      end
      burst = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(4, 10)) begin
        frame_len = $urandom_range(1, 6);
        for (int unsigned i = 0; i < frame_len; i++) begin
          has  = ($urandom_range(0, 6) != 0);
          last = (i == frame_len - 1) || ($urandom_range(0, 19) == 0);
          send_contribution(random_sample(), random_sample(), random_gain(), has, last,
                            next_gap(burst));
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    rst_ni            <= 1'b0;
    cfg_valid_i       <= 1'b0;
    cfg_master_gain_i <= '0;
    in_valid_i        <= 1'b0;
    left_in_i         <= '0;
    right_in_i        <= '0;
    stream_gain_i     <= '0;
    has_sample_i      <= 1'b0;
    frame_end_i       <= 1'b0;
    pred_left    = '0;
    pred_right   = '0;
    master_gain  = GAIN_UNITY;
    mismatches   = 0;
    hold_request = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_unity_extremes();
    test_empty_contributions();
    test_saturation();
    test_master_gain_sweep();
    test_output_backpressure();
    test_random_mix();
    drain_frames();

    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("tb_stereo_gain_mixer_saturating: clean");
    end else begin
      $display("tb_stereo_gain_mixer_saturating: errors");
    end
    $finish;
  end

endmodule
